// File: rtl/prbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prbm_pkg
// Types, codes and saturating helpers for the pixel range background model.
// ----------------------------------------------------------------------------
package prbm_pkg;

    localparam logic [7:0] K8_00 = 8'h00;
    localparam logic [7:0] K8_01 = 8'h01;
    localparam logic [7:0] K8_FF = 8'hFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 2'd1;

    typedef enum logic [2:0] {
        MODE_GROW_SLOW     = 3'd0,
        MODE_GROW_FAST     = 3'd1,
        MODE_COUNT         = 3'd2,
        MODE_ADJUST        = 3'd3,
        MODE_ADJUST_MASKED = 3'd4,
        MODE_SHIFT         = 3'd5,
        MODE_SHIFT_MASKED  = 3'd6
    } t_mode;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  pixel_value;
        logic [7:0]  mask_byte;
    } t_in;

    typedef struct packed {
        logic [15:0] pixel_index_out;
        logic [7:0]  new_low;
        logic [7:0]  new_high;
        logic [7:0]  new_below_count;
        logic [7:0]  new_above_count;
    } t_out;

    // one model entry, as stored in memory
    typedef struct packed {
        logic [7:0] low;
        logic [7:0] high;
        logic [7:0] below;
        logic [7:0] above;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{low: K8_FF, high: K8_00, below: K8_00, above: K8_00};

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? K8_FF : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : K8_00;
    endfunction

endpackage
`default_nettype wire

// File: rtl/pixel_range_background_model_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_range_background_model_top
// Per-pixel min/max range background model, one entry per pixel in memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  cfg       in         i_cfg_we                   i_cfg_index, i_cfg_data
//  in        in         i_in_valid / o_in_ready    i_in  (t_in)
//  out       out        o_out_valid / i_out_ready  o_out (t_out)
//
//  One item per cycle sustained while the output accepts; an accepted item
//  passes index reduction over three stages, memory read and update.
//  After reset a clearing pass writes the reset entry to every memory word
//  with o_in_ready low; config is taken.
//  Stages advance independently, so bubbles collapse under an output stall;
//  a same-pixel item right behind another gets the fresh entry forwarded.
// ----------------------------------------------------------------------------
module pixel_range_background_model_top #(
    parameter int NUM_PIXELS = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [prbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  prbm_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output prbm_pkg::t_out                 o_out
);
    import prbm_pkg::*;

    // only the first 2^16 pixels are reachable by a 16-bit index
    localparam int DEPTH = (NUM_PIXELS < 65536) ? NUM_PIXELS : 65536;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DEPTH);

    // configuration
    logic [2:0] r_pass_mode;
    logic [7:0] r_threshold;

    // pipeline valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic load1, load2, load3, load4, load_o;

    // stage payloads
    logic [15:0] r_idx1, r_idx2, r_idx3, r_idx4;
    logic [7:0]  r_val1, r_val2, r_val3, r_val4;
    logic [7:0]  r_msk1, r_msk2, r_msk3, r_msk4;
    logic [15:0] r_q1;
    logic [15:0] r_qn2;
    logic [AW-1:0] r_p3, r_p4;
    t_entry      r_rd4;
    logic        r_fwd4;
    t_out        r_out;

    // clearing pass
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    t_entry        mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    logic [48:0]   prod1;
    logic [15:0]   rem_a, rem_b;
    logic [AW-1:0] n_p3;
    t_entry        cur4, upd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_mode <= MODE_GROW_SLOW;
            r_threshold <= K8_00;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PASS_MODE)       r_pass_mode <= i_cfg_data[2:0];
            if (i_cfg_index == CFG_COUNT_THRESHOLD) r_threshold <= i_cfg_data;
        end
    end

    assign load_o = !r_vo || i_out_ready;
    assign load4  = !r_v4 || load_o;
    assign load3  = !r_v3 || load4;
    assign load2  = !r_v2 || load3;
    assign load1  = !r_v1 || load2;
    assign o_in_ready = load1 && !r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (load1)  r_v1 <= i_in_valid && !r_clr;
            if (load2)  r_v2 <= r_v1;
            if (load3)  r_v3 <= r_v2;
            if (load4)  r_v4 <= r_v3;
            if (load_o) r_vo <= r_v4;
        end
    end

    // index modulo DEPTH: reciprocal estimate, back-multiply, one correction
    assign prod1 = 49'(i_in.pixel_index) * 49'(RECIP);

    always_comb begin
        rem_a = r_idx2 - r_qn2;
        rem_b = rem_a - 16'(DEPTH);
        n_p3  = ({1'b0, rem_a} >= 17'(DEPTH)) ? rem_b[AW-1:0] : rem_a[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_idx1 <= i_in.pixel_index;
            r_val1 <= i_in.pixel_value;
            r_msk1 <= i_in.mask_byte;
            r_q1   <= prod1[47:32];
        end
        if (load2) begin
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
            r_msk2 <= r_msk1;
            r_qn2  <= 16'(r_q1 * 17'(DEPTH));
        end
        if (load3) begin
            r_idx3 <= r_idx2;
            r_val3 <= r_val2;
            r_msk3 <= r_msk2;
            r_p3   <= n_p3;
        end
        if (load4) begin
            r_idx4 <= r_idx3;
            r_val4 <= r_val3;
            r_msk4 <= r_msk3;
            r_p4   <= r_p3;
            // the item leaving stage 4 now writes the word being read now
            r_fwd4 <= r_v4 && (r_p4 == r_p3);
        end
        if (load_o) begin
            r_out.pixel_index_out <= r_idx4;
            r_out.new_low         <= upd4.low;
            r_out.new_high        <= upd4.high;
            r_out.new_below_count <= upd4.below;
            r_out.new_above_count <= upd4.above;
        end
    end

    // output register still holds the entry of the item that was forwarded
    assign cur4 = r_fwd4 ? '{low:   r_out.new_low,
                             high:  r_out.new_high,
                             below: r_out.new_below_count,
                             above: r_out.new_above_count} : r_rd4;

    prbm_update u_update (
        .i_mode      (r_pass_mode),
        .i_threshold (r_threshold),
        .i_value     (r_val4),
        .i_mask      (r_msk4),
        .i_entry     (cur4),
        .o_entry     (upd4)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) r_clr <= 1'b0;
        end
    end

    assign mem_we    = r_clr || (r_v4 && load_o);
    assign mem_waddr = r_clr ? r_clr_addr : r_p4;
    assign mem_wdata = r_clr ? ENTRY_RESET : upd4;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (load4)  r_rd4 <= mem[r_p3];
    end

    assign o_out_valid = r_vo;
    assign o_out       = r_out;

    // clearing pass ends only after the last word
    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr) |-> ($past(r_clr_addr) == AW'(DEPTH - 1)))
        else $error("clearing pass ended early");

    // no item is in flight while memory is being cleared
    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !(r_v1 || r_v2 || r_v3 || r_v4 || r_vo))
        else $error("item in pipeline during clearing pass");

    // a same-pixel item right behind another is forwarded, with the preceding item in the output stage
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load4 && r_v4 && r_v3 && (r_p4 == r_p3)) |=> (r_fwd4 && r_vo))
        else $error("forwarding source missing");

endmodule
`default_nettype wire

// File: rtl/prbm_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prbm_update
// Entry update for one item: applies the pass mode to a model entry.
// ----------------------------------------------------------------------------
module prbm_update (
    input  logic [2:0]      i_mode,
    input  logic [7:0]      i_threshold,
    input  logic [7:0]      i_value,
    input  logic [7:0]      i_mask,
    input  prbm_pkg::t_entry i_entry,
    output prbm_pkg::t_entry o_entry
);
    import prbm_pkg::*;

    always_comb begin
        logic [7:0] lo, hi, bc, ac, add, sub;
        logic       en;
        lo  = i_entry.low;
        hi  = i_entry.high;
        bc  = i_entry.below;
        ac  = i_entry.above;
        add = K8_00;
        sub = K8_00;
        en  = 1'b0;
        case (i_mode)
            MODE_GROW_SLOW: begin
                if (i_value > hi) hi = sat_add8(hi, K8_01);
                if (i_value < lo) lo = sat_sub8(lo, K8_01);
            end
            MODE_GROW_FAST: begin
                if (i_value < lo) lo = i_value;
                if (i_value > hi) hi = i_value;
            end
            MODE_COUNT: begin
                if (i_value < lo) bc = sat_add8(bc, K8_01);
                if (i_value > hi) ac = sat_add8(ac, K8_01);
            end
            MODE_ADJUST, MODE_ADJUST_MASKED: begin
                en = (i_mode == MODE_ADJUST) || i_mask[0];
                if (en) begin
                    lo = sat_sub8(sat_add8(lo, {7'b0, bc < i_threshold}),
                                  {7'b0, bc > i_threshold});
                    hi = sat_sub8(sat_add8(hi, {7'b0, ac > i_threshold}),
                                  {7'b0, ac < i_threshold});
                end
                bc = K8_00;
                ac = K8_00;
            end
            MODE_SHIFT, MODE_SHIFT_MASKED: begin
                add = sat_sub8(i_value, hi);
                sub = sat_sub8(lo, i_value);
                if (i_mode == MODE_SHIFT_MASKED) begin
                    add = add & i_mask;
                    sub = sub & i_mask;
                end
                lo = sat_sub8(sat_add8(lo, add), sub);
                hi = sat_sub8(sat_add8(hi, add), sub);
            end
            default: begin
                // unused mode: entry left as it stands
            end
        endcase
        o_entry = '{low: lo, high: hi, below: bc, above: ac};
    end

endmodule
`default_nettype wire

// File: tb/tb_pixel_range_background_model_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_range_background_model_top
// Drives pixel items through the range background model under random idling
// and output back-pressure. A local copy of the per-pixel model predicts each
// updated entry, and every result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pixel_range_background_model_top;
    import prbm_pkg::*;

    localparam int NUM_PIXELS     = 65536;
    localparam int WATCHDOG_LIMIT = 300000;   // covers the clearing pass after reset
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 100;
    localparam int RANDOM_ITEMS   = 1140;
    localparam int QUIET_TAIL     = 200;
    localparam int SAT_ITEMS      = 270;
    localparam int LONG_HOLD      = 300;

    localparam logic [2:0]           MODE_RESERVED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
    localparam logic [15:0]          BELOW_PIXEL   = 16'h0107;
    localparam logic [15:0]          ABOVE_PIXEL   = 16'h0108;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out;

    // predicted model state and registers
    logic [7:0] bg_low   [NUM_PIXELS];
    logic [7:0] bg_high  [NUM_PIXELS];
    logic [7:0] bg_below [NUM_PIXELS];
    logic [7:0] bg_above [NUM_PIXELS];
    logic [2:0] cur_mode;
    logic [7:0] cur_thr;

    t_in  pixel_queue[$];
    t_out expected_entries[$];

    bit in_taken       = 1'b0;
    int mismatch_count = 0;
    int idle_cycles    = 0;
    int send_gap       = 0;
    int send_gap_pct   = 0;
    int recv_stall     = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int out_hold       = 0;

    pixel_range_background_model_top #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] add_clip(input logic [7:0] a, input logic [7:0] b);
        int s;
        s = int'(a) + int'(b);
        return (s > 255) ? K8_FF : s[7:0];
    endfunction

    function automatic logic [7:0] sub_clip(input logic [7:0] a, input logic [7:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? K8_00 : d[7:0];
    endfunction

    function automatic t_out update_pixel_model(input t_in item);
        int         p;
        logic [7:0] lo, hi, bc, ac, v, m, up, dn;
        t_out       res;
        p  = int'(item.pixel_index) % NUM_PIXELS;
        v  = item.pixel_value;
        m  = item.mask_byte;
        lo = bg_low[p];
        hi = bg_high[p];
        bc = bg_below[p];
        ac = bg_above[p];
        case (cur_mode)
            MODE_GROW_SLOW: begin
                if (v > hi) hi = add_clip(hi, K8_01);
                if (v < lo) lo = sub_clip(lo, K8_01);
            end
            MODE_GROW_FAST: begin
                if (v < lo) lo = v;
                if (v > hi) hi = v;
            end
            MODE_COUNT: begin
                if (v < lo) bc = add_clip(bc, K8_01);
                if (v > hi) ac = add_clip(ac, K8_01);
            end
            MODE_ADJUST, MODE_ADJUST_MASKED: begin
                if (cur_mode == MODE_ADJUST || m[0]) begin
                    lo = sub_clip(add_clip(lo, {7'd0, bc < cur_thr}), {7'd0, bc > cur_thr});
                    hi = sub_clip(add_clip(hi, {7'd0, ac > cur_thr}), {7'd0, ac < cur_thr});
                end
                bc = K8_00;
                ac = K8_00;
            end
            MODE_SHIFT, MODE_SHIFT_MASKED: begin
                up = sub_clip(v, hi);
                dn = sub_clip(lo, v);
                if (cur_mode == MODE_SHIFT_MASKED) begin
                    up = up & m;
                    dn = dn & m;
                end
                lo = sub_clip(add_clip(lo, up), dn);
                hi = sub_clip(add_clip(hi, up), dn);
            end
            default: begin
                // reserved mode: entry stays as it is
            end
        endcase
        bg_low[p]   = lo;
        bg_high[p]  = hi;
        bg_below[p] = bc;
        bg_above[p] = ac;
        res.pixel_index_out = item.pixel_index;
        res.new_low         = lo;
        res.new_high        = hi;
        res.new_below_count = bc;
        res.new_above_count = ac;
        return res;
    endfunction

    // mostly a small pool of hot pixels, with repeats and values near the bounds
    function automatic t_in random_pixel_item(input logic [15:0] prev_idx);
        t_in it;
        int  sel;
        int  near;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            it.pixel_index = prev_idx;
        else if (sel < 80)
            it.pixel_index = {($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000,
                              4'($urandom_range(0, 15))};
        else
            it.pixel_index = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            it.pixel_value = ($urandom_range(0, 1) != 0) ? K8_FF : K8_00;
        end else if (sel < 60) begin
            near = ($urandom_range(0, 1) != 0) ? int'(bg_low[it.pixel_index])
                                                : int'(bg_high[it.pixel_index]);
            near = near + int'($urandom_range(0, 4)) - 2;
            if (near < 0) near = 0;
            else if (near > 255) near = 255;
            it.pixel_value = 8'(near);
        end else begin
            it.pixel_value = 8'($urandom);
        end
        sel = $urandom_range(0, 99);
        if (sel < 15) it.mask_byte = K8_00;
        else if (sel < 30) it.mask_byte = K8_FF;
        else it.mask_byte = 8'($urandom);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_PASS_MODE) cur_mode = data[2:0];
        else if (idx == CFG_COUNT_THRESHOLD) cur_thr = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_mode_threshold(input logic [2:0] mode, input logic [7:0] thr);
        cfg_write(CFG_PASS_MODE, {5'($urandom), mode});
        cfg_write(CFG_COUNT_THRESHOLD, thr);
    endtask

    task automatic queue_item(input logic [15:0] idx, input logic [7:0] val,
                              input logic [7:0] mask);
        t_in it;
        it.pixel_index = idx;
        it.pixel_value = val;
        it.mask_byte   = mask;
        pixel_queue.push_back(it);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || expected_entries.size() != 0);
        @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (send_gap == 0 && send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
                send_gap = $urandom_range(1, 12);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                i_in       <= pixel_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            out_hold     = hold_request;
            hold_request = 0;
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else begin
            if (recv_stall == 0 && recv_stall_pct > 0 &&
                $urandom_range(0, 99) < recv_stall_pct)
                recv_stall = $urandom_range(1, 12);
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin : monitor
        t_out got;
        t_out want;
        bit   out_taken;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (out_taken) begin
            got = o_out;
            if (expected_entries.size() == 0) begin
                report_mismatch("result with none pending, pixel", got.pixel_index_out, '0);
            end else begin
                want = expected_entries.pop_front();
                if (got.pixel_index_out !== want.pixel_index_out)
                    report_mismatch("pixel_index_out", got.pixel_index_out,
                                    want.pixel_index_out);
                if (got.new_low !== want.new_low)
                    report_mismatch("new_low", 16'(got.new_low), 16'(want.new_low));
                if (got.new_high !== want.new_high)
                    report_mismatch("new_high", 16'(got.new_high), 16'(want.new_high));
                if (got.new_below_count !== want.new_below_count)
                    report_mismatch("new_below_count", 16'(got.new_below_count),
                                    16'(want.new_below_count));
                if (got.new_above_count !== want.new_above_count)
                    report_mismatch("new_above_count", 16'(got.new_above_count),
                                    16'(want.new_above_count));
            end
        end
        if (in_taken)
            expected_entries.push_back(update_pixel_model(i_in));
        if (i_rst_n) begin
            if (in_taken || out_taken) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int          n_rand;
        int          n_phase;
        int          n_below;
        int          n_above;
        int          sel;
        logic [2:0]  mode;
        logic [7:0]  thr;
        logic [15:0] last_idx;
        t_in         it;

        foreach (bg_low[i]) begin
            bg_low[i]   = K8_FF;
            bg_high[i]  = K8_00;
            bg_below[i] = K8_00;
            bg_above[i] = K8_00;
        end
        cur_mode = MODE_GROW_SLOW;
        cur_thr  = K8_00;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_gap_pct   = 10;
        recv_stall_pct = 10;

        // these writes land during the clearing pass
        set_mode_threshold(MODE_GROW_SLOW, K8_00);
        queue_item(16'h0000, K8_00, K8_00);
        queue_item(16'h0000, K8_FF, K8_FF);
        queue_item(16'hFFFF, 8'h80, 8'hFF);
        wait_drained();

        set_mode_threshold(MODE_GROW_FAST, 8'h10);
        queue_item(16'h0001, 8'h0A, K8_00);
        queue_item(16'h0001, 8'hC8, K8_00);
        queue_item(16'h0001, 8'h64, K8_00);    // inside the range
        queue_item(16'hFFFF, K8_FF, K8_00);
        wait_drained();

        set_mode_threshold(MODE_COUNT, K8_01);
        queue_item(16'h0001, 8'h05, 8'h3C);
        queue_item(16'h0001, 8'hFA, 8'hC3);
        queue_item(16'h0001, 8'h64, 8'h00);
        queue_item(16'h0002, K8_00, K8_FF);
        wait_drained();

        set_mode_threshold(MODE_ADJUST, K8_01);
        queue_item(16'h0001, 8'h33, K8_00);     // counts equal the threshold
        queue_item(16'h0002, 8'h33, K8_00);
        queue_item(16'h0003, 8'h33, K8_00);     // fresh pixel: bounds pinned at the rails
        wait_drained();

        set_mode_threshold(MODE_ADJUST_MASKED, K8_00);
        queue_item(16'h0002, 8'h11, 8'hFE);     // enable bit clear, counts still cleared
        queue_item(16'h0001, 8'h11, K8_01);
        wait_drained();

        set_mode_threshold(MODE_SHIFT, K8_FF);
        queue_item(16'h0001, K8_FF, K8_00);
        queue_item(16'h0001, K8_00, K8_00);
        queue_item(16'h0004, 8'h80, K8_00);
        wait_drained();

        set_mode_threshold(MODE_SHIFT_MASKED, 8'h80);
        queue_item(16'h0005, 8'hC8, 8'hAA);
        queue_item(16'h0005, 8'h03, 8'h55);
        wait_drained();

        set_mode_threshold(MODE_RESERVED, 8'h7F);
        queue_item(16'h0001, 8'h4D, K8_FF);
        wait_drained();
        // writes to indexes past the register list must not disturb anything
        cfg_write(CFG_SPARE_A, K8_FF);
        cfg_write(CFG_SPARE_B, K8_FF);
        queue_item(16'hFFFF, 8'h4D, K8_00);
        wait_drained();

        // drive two pixels' counts into saturation while the receiver holds off
        set_mode_threshold(MODE_COUNT, 8'($urandom));
        hold_request = LONG_HOLD;
        n_below = 0;
        n_above = 0;
        while (n_below < SAT_ITEMS || n_above < SAT_ITEMS) begin
            if (n_above >= SAT_ITEMS || (n_below < SAT_ITEMS && $urandom_range(0, 1) != 0)) begin
                queue_item(BELOW_PIXEL, 8'($urandom_range(0, 254)), 8'($urandom));
                n_below++;
            end else begin
                queue_item(ABOVE_PIXEL, 8'($urandom_range(1, 255)), 8'($urandom));
                n_above++;
            end
        end
        wait_drained();
        set_mode_threshold(MODE_ADJUST_MASKED, K8_FF);
        queue_item(BELOW_PIXEL, 8'h20, K8_01);
        queue_item(ABOVE_PIXEL, 8'h20, K8_FF);
        wait_drained();

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            if (n_rand >= RANDOM_ITEMS - QUIET_TAIL) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else begin
                send_gap_pct   = 10 * $urandom_range(0, 3);
                recv_stall_pct = 10 * $urandom_range(0, 3);
            end
            sel  = $urandom_range(0, 99);
            mode = (sel < 4) ? MODE_RESERVED : 3'($urandom_range(0, 6));
            sel  = $urandom_range(0, 99);
            if (sel < 20) thr = K8_00;
            else if (sel < 40) thr = K8_FF;
            else if (sel < 75) thr = 8'($urandom_range(0, 6));
            else thr = 8'($urandom);
            set_mode_threshold(mode, thr);
            n_phase  = $urandom_range(30, 90);
            last_idx = 16'($urandom_range(0, 15));
            repeat (n_phase) begin
                it = random_pixel_item(last_idx);
                pixel_queue.push_back(it);
                last_idx = it.pixel_index;
            end
            n_rand += n_phase;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_entries.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
